[hw/rtl/lsc_pkg.sv]
package lsc_pkg;

  localparam int DATA_WIDTH = 48;
  localparam int FUNC_WIDTH = 3;

  localparam logic [FUNC_WIDTH-1:0] OP_TICK  = 3'd0;
  localparam logic [FUNC_WIDTH-1:0] OP_START = 3'd1;
  localparam logic [FUNC_WIDTH-1:0] OP_STOP  = 3'd2;
  localparam logic [FUNC_WIDTH-1:0] OP_RESET = 3'd3;
  localparam logic [FUNC_WIDTH-1:0] OP_LAP   = 3'd4;
  localparam logic [FUNC_WIDTH-1:0] OP_READ  = 3'd5;

  typedef struct packed {
    logic [FUNC_WIDTH-1:0] func;
    logic [DATA_WIDTH-1:0] lap_modulus;
  } req_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] laps;
    logic [DATA_WIDTH-1:0] elapsed_count;
    logic                  is_running;
  } rsp_item_t;

endpackage

[hw/rtl/lsc_stream_if.sv]
interface lsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/lap_stopwatch_counter.sv]
// tick, start, stop, reset, read and a lap by zero load their result into the output
// register in the cycle after acceptance; while rsp is not stalled, one such item per
// cycle is sustained; a lap by a nonzero modulus runs a restoring divider, one
// quotient bit per cycle, then S_DONE waits for a free output; input held off meanwhile
// reset (rst, synchronous, active high) clears the count, stops the stopwatch
// and drops any pending result
module lap_stopwatch_counter #(
  parameter int COUNT_WIDTH = 48
) (
  input logic        clk,
  input logic        rst,
  lsc_stream_if.sink   req,
  lsc_stream_if.source rsp
);

  localparam int DW     = lsc_pkg::DATA_WIDTH;
  localparam int STEP_W = $clog2(COUNT_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state;
  logic [COUNT_WIDTH-1:0] count;
  logic                   running;
  logic                   out_valid;
  lsc_pkg::rsp_item_t     out_data;

  // divider registers
  logic [DW-1:0]          divisor;
  logic [DW-1:0]          rem;
  logic [COUNT_WIDTH-1:0] quo;
  logic [STEP_W-1:0]      step;

  logic [COUNT_WIDTH-1:0] count_next;
  logic                   running_next;
  logic [DW-1:0]          count_next_out;
  logic [DW-1:0]          quo_out;
  logic [COUNT_WIDTH-1:0] rem_count;

  logic [DW:0]            shifted;
  logic [DW+1:0]          diff;
  logic                   fits;

  logic out_free;
  logic accept;
  logic lap_div;
  logic load_out;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign lap_div   = (req.data.func == lsc_pkg::OP_LAP) && (req.data.lap_modulus != '0);
  assign load_out  = (accept && !lap_div) || ((state == S_DONE) && out_free);

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // next count and run state for the items that bypass the divider
  always_comb begin
    count_next   = count;
    running_next = running;
    unique case (req.data.func)
      lsc_pkg::OP_TICK:  if (running && !(&count)) count_next = count + 1'b1;
      lsc_pkg::OP_START: running_next = 1'b1;
      lsc_pkg::OP_STOP:  running_next = 1'b0;
      lsc_pkg::OP_RESET: count_next = '0;
      default: ;
    endcase
  end

  // shared subtract and compare of the divider
  assign shifted = {rem, quo[COUNT_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = !diff[DW+1];

  generate
    if (COUNT_WIDTH >= DW) begin : g_wide
      assign count_next_out = count_next[DW-1:0];
      assign quo_out        = quo[DW-1:0];
      assign rem_count      = {{(COUNT_WIDTH-DW){1'b0}}, rem};
    end else begin : g_narrow
      assign count_next_out = {{(DW-COUNT_WIDTH){1'b0}}, count_next};
      assign quo_out        = {{(DW-COUNT_WIDTH){1'b0}}, quo};
      // remainder never exceeds the count, so the high bits are zero
      assign rem_count      = rem[COUNT_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (lap_div) begin
              divisor <= req.data.lap_modulus;
              rem     <= '0;
              quo     <= count;
              step    <= STEP_W'(COUNT_WIDTH - 1);
              state   <= S_DIV;
            end else begin
              count                  <= count_next;
              running                <= running_next;
              out_data.laps          <= '0;
              out_data.elapsed_count <= count_next_out;
              out_data.is_running    <= running_next;
            end
          end
        end
        S_DIV: begin
          rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
          quo <= {quo[COUNT_WIDTH-2:0], fits};
          if (step == '0) state <= S_DONE;
          else step <= step - 1'b1;
        end
        S_DONE: begin
          // wait here until the output register can take the result
          if (out_free) begin
            count                  <= rem_count;
            out_data.laps          <= quo_out;
            out_data.elapsed_count <= rem;
            out_data.is_running    <= running;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_lap_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && lap_div) |=> (state == S_DIV) && !req.ready)
    else $error("nonzero lap did not start the divider");

  a_count_held_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> $stable(count) && $stable(running))
    else $error("count or running changed while dividing");

  a_quick_op_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !lap_div) |=> rsp.valid && (rsp.data.laps == '0))
    else $error("single-cycle item gave no result or nonzero laps");

endmodule

[dv/lap_stopwatch_counter_tb.sv]
module lap_stopwatch_counter_tb;

  // a narrow count exercises the zero-extended output path
  localparam int CW = 16;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [lsc_pkg::FUNC_WIDTH-1:0] OP_SPARE6 = 3'd6;
  localparam logic [lsc_pkg::FUNC_WIDTH-1:0] OP_SPARE7 = 3'd7;
  localparam logic [lsc_pkg::DATA_WIDTH-1:0] ALL_ONES = '1;
  localparam int STUCK_LIMIT = 1000;
  localparam int IDLE_PCT = 35;

  typedef struct {
    lsc_pkg::req_item_t item;
    bit                 drain;
    bit                 quiet;
  } op_entry_t;

  logic clk;
  logic rst;

  lsc_stream_if #(.payload_t(lsc_pkg::req_item_t)) req_if ();
  lsc_stream_if #(.payload_t(lsc_pkg::rsp_item_t)) rsp_if ();

  lap_stopwatch_counter #(.COUNT_WIDTH(CW)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  op_entry_t op_queue[$];
  bit        hold_next;
  bit        fill_quiet;

  // expected readings, circular buffer indexed with nonblocking pointers
  lsc_pkg::rsp_item_t want_reading [256];
  logic [7:0]  want_wr;
  logic [7:0]  want_rd;
  bit          quiet;
  int          n_err;
  int          stuck;

  logic [CW-1:0] watch_count;
  bit            watch_running;

  function automatic lsc_pkg::rsp_item_t advance_watch(lsc_pkg::req_item_t r);
    lsc_pkg::rsp_item_t o;
    logic [lsc_pkg::DATA_WIDTH-1:0] wide;
    o = '0;
    wide = lsc_pkg::DATA_WIDTH'(watch_count);
    case (r.func)
      lsc_pkg::OP_TICK: begin
        if (watch_running && watch_count != CNT_MAX) watch_count = watch_count + 1'b1;
      end
      lsc_pkg::OP_START: watch_running = 1'b1;
      lsc_pkg::OP_STOP:  watch_running = 1'b0;
      lsc_pkg::OP_RESET: watch_count = '0;
      lsc_pkg::OP_LAP: begin
        if (r.lap_modulus != '0) begin
          o.laps = wide / r.lap_modulus;
          wide = wide % r.lap_modulus;
          watch_count = wide[CW-1:0];
        end
      end
      default: ;
    endcase
    o.elapsed_count = lsc_pkg::DATA_WIDTH'(watch_count);
    o.is_running = watch_running;
    return o;
  endfunction

  function automatic logic [lsc_pkg::DATA_WIDTH-1:0] rand48();
    return lsc_pkg::DATA_WIDTH'({$urandom, $urandom});
  endfunction

  function automatic logic [lsc_pkg::DATA_WIDTH-1:0] rand_modulus();
    case ($urandom_range(9))
      0: return '0;
      7: return lsc_pkg::DATA_WIDTH'($urandom_range(300, 1));
      8: return rand48();
      9: return ALL_ONES >> $urandom_range(47);
      default: return lsc_pkg::DATA_WIDTH'($urandom_range(40, 1));
    endcase
  endfunction

  task automatic add_op(logic [lsc_pkg::FUNC_WIDTH-1:0] f,
                        logic [lsc_pkg::DATA_WIDTH-1:0] m);
    op_entry_t e;
    e.item.func = f;
    e.item.lap_modulus = m;
    e.drain = hold_next;
    e.quiet = fill_quiet;
    hold_next = 1'b0;
    op_queue.push_back(e);
  endtask

  task automatic check_field(string name, logic [lsc_pkg::DATA_WIDTH-1:0] want,
                             logic [lsc_pkg::DATA_WIDTH-1:0] got);
    if (want !== got) begin
      if (n_err < 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
      n_err++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: predicts on acceptance, then offers the next item
  always @(posedge clk) begin
    logic fire;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      want_wr <= '0;
      quiet <= 1'b0;
      watch_count = '0;
      watch_running = 1'b0;
    end else begin
      fire = req_if.valid && req_if.ready;
      if (fire) begin
        want_reading[want_wr] <= advance_watch(req_if.data);
        want_wr <= want_wr + 1'b1;
      end
      if (req_if.valid && !fire) begin
        // hold the offered item
      end else if (op_queue.size() != 0 &&
                   (!op_queue[0].drain || (want_wr == want_rd && !fire)) &&
                   (op_queue[0].quiet || $urandom_range(99) >= IDLE_PCT)) begin
        req_if.valid <= 1'b1;
        req_if.data <= op_queue[0].item;
        quiet <= op_queue[0].quiet;
        op_queue.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor: compares each reading with the oldest expectation
  always @(posedge clk) begin
    lsc_pkg::rsp_item_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      want_rd <= '0;
      n_err = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (want_wr == want_rd) begin
          if (n_err < 10) $display("unexpected item on output: %p", rsp_if.data);
          n_err++;
        end else begin
          want = want_reading[want_rd];
          check_field("laps", want.laps, rsp_if.data.laps);
          check_field("elapsed_count", want.elapsed_count, rsp_if.data.elapsed_count);
          check_field("is_running", lsc_pkg::DATA_WIDTH'(want.is_running),
                      lsc_pkg::DATA_WIDTH'(rsp_if.data.is_running));
          want_rd <= want_rd + 1'b1;
        end
      end
      rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [lsc_pkg::FUNC_WIDTH-1:0] f;
    int r;
    hold_next = 1'b0;
    fill_quiet = 1'b0;

    // directed: idle ops, repeats, laps by zero, one, small moduli and all ones, spare codes
    add_op(lsc_pkg::OP_READ, '0);
    add_op(lsc_pkg::OP_TICK, ALL_ONES);
    add_op(lsc_pkg::OP_STOP, '0);
    add_op(lsc_pkg::OP_LAP, 48'd5);
    add_op(lsc_pkg::OP_START, '0);
    add_op(lsc_pkg::OP_START, ALL_ONES);
    repeat (4) add_op(lsc_pkg::OP_TICK, '0);
    add_op(lsc_pkg::OP_LAP, '0);
    add_op(lsc_pkg::OP_LAP, 48'd3);
    repeat (2) add_op(lsc_pkg::OP_TICK, '0);
    add_op(lsc_pkg::OP_LAP, ALL_ONES);
    add_op(lsc_pkg::OP_LAP, 48'd1);
    repeat (2) add_op(lsc_pkg::OP_TICK, '0);
    add_op(lsc_pkg::OP_STOP, '0);
    add_op(lsc_pkg::OP_TICK, '0);
    add_op(lsc_pkg::OP_RESET, '0);
    add_op(lsc_pkg::OP_START, '0);
    add_op(lsc_pkg::OP_TICK, '0);
    add_op(lsc_pkg::OP_RESET, ALL_ONES);
    add_op(OP_SPARE6, 48'h5555_5555_5555);
    add_op(OP_SPARE7, 48'hAAAA_AAAA_AAAA);

    // wait for the pipe to empty, then count up and divide
    hold_next = 1'b1;
    add_op(lsc_pkg::OP_START, '0);
    repeat (20) add_op(lsc_pkg::OP_TICK, '0);
    add_op(lsc_pkg::OP_READ, '0);
    add_op(lsc_pkg::OP_LAP, 48'd7);
    add_op(lsc_pkg::OP_LAP, 48'd1);
    add_op(lsc_pkg::OP_RESET, '0);

    for (int i = 0; i < 650; i++) begin
      if (i == 200 || i == 500) hold_next = 1'b1;
      fill_quiet = (i >= 250 && i < 400);
      r = $urandom_range(99);
      if (r < 50) f = lsc_pkg::OP_TICK;
      else if (r < 57) f = lsc_pkg::OP_START;
      else if (r < 62) f = lsc_pkg::OP_STOP;
      else if (r < 66) f = lsc_pkg::OP_RESET;
      else if (r < 80) f = lsc_pkg::OP_LAP;
      else if (r < 88) f = lsc_pkg::OP_READ;
      else if (r < 94) f = OP_SPARE6;
      else f = OP_SPARE7;
      if (f == lsc_pkg::OP_LAP || $urandom_range(1) == 0) add_op(f, rand_modulus());
      else add_op(f, rand48());
    end

    while (op_queue.size() != 0 || req_if.valid || want_wr != want_rd) @(posedge clk);
    repeat (CW + 8) @(posedge clk);
    if (n_err == 0 && want_wr == want_rd) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
